// ===== rtl/dcc_pkg.sv =====
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared types and constants of the day count to calendar date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dcc_pkg;

  localparam int DAY_BITS_DEF = 27;

  localparam int YEAR_W  = 19;
  localparam int MONTH_W = 4;
  localparam int DOM_W   = 5;
  localparam int WD_W    = 3;
  localparam int DOE_W   = 18;
  localparam int DOY_W   = 9;
  localparam int YOE_W   = 9;
  localparam int MP_W    = 4;

  localparam longint unsigned DAYS_400Y  = 64'd146097;
  localparam longint unsigned DAYS_100Y  = 64'd36524;
  localparam longint unsigned MAR1_YEAR0 = 64'd60;
  localparam longint unsigned WD_SHIFT   = 64'd59;

  // Estimate of 2^40 / DAYS_400Y, used on the day count with its low 8 bits dropped.
  localparam int ERA_RECIP_W = 23;
  localparam logic [ERA_RECIP_W-1:0] ERA_RECIP =
    ERA_RECIP_W'((64'd1 << 40) / DAYS_400Y);

  // Exact reciprocals: ceil(2^S / divisor) for the operand ranges used here.
  localparam logic [18:0] RECIP_1460 = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] RECIP_365  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [18:0] RECIP_7    = 19'(((64'd1 << 21) + 64'd6) / 64'd7);
  localparam logic [9:0]  RECIP_100  = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [11:0] RECIP_153  = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

  localparam logic [MP_W-1:0] MP_JANUARY = 4'd10;

  typedef struct packed {
    logic [YEAR_W-1:0] era;
    logic [DOE_W-1:0]  doe;
  } era_item_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [DOY_W-1:0]  doy;
    logic [WD_W-1:0]   weekday;
  } date_item_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month_index;
    logic [DOM_W-1:0]   day_index;
    logic [WD_W-1:0]    weekday;
  } result_t;

  // First day of each month counted from 1 March, March first.
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dcc_era.sv =====
// ----------------------------------------------------------------------------
// dcc_era
// Splits the day count into a 400-year era and the day within that era.
// ----------------------------------------------------------------------------
`default_nettype none

module dcc_era #(
  parameter int DAY_BITS = dcc_pkg::DAY_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DAY_BITS-1:0]   day_number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dcc_pkg::era_item_t    out_item
);
  import dcc_pkg::*;

  localparam int ZW = DAY_BITS + 1;
  localparam int HW = DAY_BITS - 7;
  localparam int PW = HW + ERA_RECIP_W;
  localparam int QW = DAY_BITS - 16;
  localparam int RW = DOE_W + 1;

  localparam longint unsigned BIAS_ERAS =
    ((64'd1 << (DAY_BITS - 1)) + MAR1_YEAR0 + DAYS_400Y - 64'd1) / DAYS_400Y;
  localparam logic [ZW-1:0] Z_OFFSET = ZW'(BIAS_ERAS * DAYS_400Y - MAR1_YEAR0);

  logic          v1, v2, v3, v4;
  logic          rdy1, rdy2, rdy3, rdy4;
  logic [ZW-1:0] zu1, zu2;
  logic [QW-1:0] q2, q3;
  logic [RW-1:0] r3;

  logic [ZW-1:0] zu_next;
  logic [PW-1:0] prod;
  logic [RW-1:0] r_next;
  logic          wrap;
  logic [QW-1:0] q_fix;
  era_item_t     item_next;

  assign rdy4     = !v4 || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    zu_next = {day_number[DAY_BITS-1], day_number} + Z_OFFSET;
    prod    = PW'(zu1[ZW-1:8]) * PW'(ERA_RECIP);
    r_next  = RW'(zu2 - ZW'(q2) * ZW'(DAYS_400Y));
    wrap    = (r3 >= RW'(DAYS_400Y));
    q_fix   = q3 + QW'(wrap);
    item_next.doe = wrap ? DOE_W'(r3 - RW'(DAYS_400Y)) : r3[DOE_W-1:0];
    item_next.era = YEAR_W'(q_fix) - YEAR_W'(BIAS_ERAS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      zu1 <= zu_next;
    end
    if (rdy2) begin
      zu2 <= zu1;
      q2  <= prod[PW-1:32];
    end
    if (rdy3) begin
      r3 <= r_next;
      q3 <= q2;
    end
    if (rdy4) begin
      out_item <= item_next;
    end
  end

  assign out_valid = v4;

endmodule

`default_nettype wire

// ===== rtl/dcc_year.sv =====
// ----------------------------------------------------------------------------
// dcc_year
// Finds the year within the era, the day of that year and the weekday.
// ----------------------------------------------------------------------------
`default_nettype none

module dcc_year (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dcc_pkg::era_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dcc_pkg::date_item_t  out_item
);
  import dcc_pkg::*;

  logic              v5, v6, v7;
  logic              rdy5, rdy6, rdy7;
  logic [DOE_W-1:0]  sum5, doe5, doe6;
  logic [YEAR_W-1:0] era5, era6;
  logic [WD_W-1:0]   wd5, wd6;
  logic [YOE_W-1:0]  yoe6;

  logic [36:0]       prod_a, prod_w, prod_y;
  logic [2:0]        cent;
  logic              last_day;
  logic [DOE_W-1:0]  sum_next, wn;
  logic [WD_W-1:0]   wd_next;
  logic [18:0]       prod_c;
  logic [DOE_W-1:0]  base;
  date_item_t        item_next;

  assign rdy7     = !v7 || out_ready;
  assign rdy6     = !v6 || rdy7;
  assign rdy5     = !v5 || rdy6;
  assign in_ready = rdy5;

  always_comb begin
    prod_a   = 37'(in_item.doe) * 37'(RECIP_1460);
    cent     = 3'(in_item.doe >= DOE_W'(DAYS_100Y))
             + 3'(in_item.doe >= DOE_W'(2 * DAYS_100Y))
             + 3'(in_item.doe >= DOE_W'(3 * DAYS_100Y))
             + 3'(in_item.doe >= DOE_W'(4 * DAYS_100Y));
    last_day = (in_item.doe == DOE_W'(DAYS_400Y - 1));
    sum_next = in_item.doe - DOE_W'(prod_a[35:29]) + DOE_W'(cent) - DOE_W'(last_day);
    wn       = in_item.doe + DOE_W'(WD_SHIFT);
    prod_w   = 37'(wn) * 37'(RECIP_7);
    wd_next  = WD_W'(wn - DOE_W'(prod_w[35:21]) * DOE_W'(7));

    prod_y   = 37'(sum5) * 37'(RECIP_365);

    prod_c   = 19'(yoe6) * 19'(RECIP_100);
    base     = DOE_W'(yoe6) * DOE_W'(365) + DOE_W'(yoe6[YOE_W-1:2])
             - DOE_W'(prod_c[17:16]);
    item_next.doy     = DOY_W'(doe6 - base);
    item_next.year    = era6 * YEAR_W'(400) + YEAR_W'(yoe6);
    item_next.weekday = wd6;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (rdy5) v5 <= in_valid;
      if (rdy6) v6 <= v5;
      if (rdy7) v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      sum5 <= sum_next;
      doe5 <= in_item.doe;
      era5 <= in_item.era;
      wd5  <= wd_next;
    end
    if (rdy6) begin
      yoe6 <= prod_y[35:27];
      doe6 <= doe5;
      era6 <= era5;
      wd6  <= wd5;
    end
    if (rdy7) begin
      out_item <= item_next;
    end
  end

  assign out_valid = v7;

endmodule

`default_nettype wire

// ===== rtl/dcc_month.sv =====
// ----------------------------------------------------------------------------
// dcc_month
// Splits the day of the year into month and day and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module dcc_month (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dcc_pkg::date_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dcc_pkg::result_t     out_item
);
  import dcc_pkg::*;

  logic              v8, v9;
  logic              rdy8, rdy9;
  logic [MP_W-1:0]   mp8;
  logic [DOY_W-1:0]  doy8;
  logic [YEAR_W-1:0] year8;
  logic [WD_W-1:0]   wd8;

  logic [10:0]       n;
  logic [22:0]       prod_m;
  logic              early;
  result_t           item_next;

  assign rdy9     = !v9 || out_ready;
  assign rdy8     = !v8 || rdy9;
  assign in_ready = rdy8;

  always_comb begin
    n      = 11'(in_item.doy) * 11'(5) + 11'(2);
    prod_m = 23'(n) * 23'(RECIP_153);
    early  = (mp8 >= MP_JANUARY);
    item_next.month_index = early ? MONTH_W'(mp8 - MP_JANUARY) : MONTH_W'(mp8 + 4'd2);
    item_next.day_index   = DOM_W'(doy8 - month_start(mp8));
    item_next.year        = year8 + YEAR_W'(early);
    item_next.weekday     = wd8;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
      v9 <= 1'b0;
    end else begin
      if (rdy8) v8 <= in_valid;
      if (rdy9) v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy8) begin
      mp8   <= prod_m[22:19];
      doy8  <= in_item.doy;
      year8 <= in_item.year;
      wd8   <= in_item.weekday;
    end
    if (rdy9) begin
      out_item <= item_next;
    end
  end

  assign out_valid = v9;

endmodule

`default_nettype wire

// ===== rtl/day_count_to_calendar_date.sv =====
// ----------------------------------------------------------------------------
// day_count_to_calendar_date
// Converts a signed day count into a proleptic Gregorian date and weekday.
// ----------------------------------------------------------------------------
// Each item on the slave stream carries a signed day count; day 0 is
// 1 January of year 0 and day 366 is 1 January of year 1. For every item
// accepted, the master stream delivers one item with the signed year, the
// zero-based month, the zero-based day of the month and the weekday
// (0 is Sunday).
// The block is a nine-stage pipeline: the 400-year era split, the year
// within the era and the month split each take a few register stages.
// One item can be accepted in every cycle while the master side does
// not stall.
// Each stage holds its item when the next one is full, so a stall on the
// master side fills the pipeline stage by stage before tready on the
// slave side drops; no item is lost or repeated.
// Reset clears all valid bits; the pipeline is empty and ready right after.
// ----------------------------------------------------------------------------
`default_nettype none

module day_count_to_calendar_date #(
  parameter int DAY_BITS = dcc_pkg::DAY_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // day_number in the low DAY_BITS bits
  input  logic [((DAY_BITS+7)/8)*8-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // year [18:0], month_index [22:19], day_index [27:23], weekday [30:28]
  output logic [31:0]                      m_tdata
);
  import dcc_pkg::*;

  logic       era_valid, era_ready;
  era_item_t  era_item;
  logic       date_valid, date_ready;
  date_item_t date_item;
  result_t    result;

  dcc_era #(
    .DAY_BITS(DAY_BITS)
  ) u_era (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .day_number(s_tdata[DAY_BITS-1:0]),
    .out_valid (era_valid),
    .out_ready (era_ready),
    .out_item  (era_item)
  );

  dcc_year u_year (
    .clk      (clk),
    .rst      (rst),
    .in_valid (era_valid),
    .in_ready (era_ready),
    .in_item  (era_item),
    .out_valid(date_valid),
    .out_ready(date_ready),
    .out_item (date_item)
  );

  dcc_month u_month (
    .clk      (clk),
    .rst      (rst),
    .in_valid (date_valid),
    .in_ready (date_ready),
    .in_item  (date_item),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_item (result)
  );

  assign m_tdata = {1'b0, result.weekday, result.day_index, result.month_index, result.year};

endmodule

`default_nettype wire

// ===== tb/sv/day_count_to_calendar_date_tb.sv =====
// ----------------------------------------------------------------------------
// day_count_to_calendar_date_tb
// Self-checking bench for the day count to calendar date converter.
// ----------------------------------------------------------------------------
// Day counts go in on the slave stream. A short directed list covers the null
// date, the field extremes, leap days, and century and era edges on both sides
// of day 0. Random counts follow, half of them full range and some near
// leap-rule boundaries. Every accepted item gets an expected date from a
// predictor in this file. Each result on the master stream is checked field by
// field against the oldest expected date. Both streams idle and stall at
// random.
// ----------------------------------------------------------------------------
`default_nettype none

module day_count_to_calendar_date_tb;

  import dcc_pkg::*;

  localparam int DAY_BITS    = 27;
  localparam int IN_W        = ((DAY_BITS + 7) / 8) * 8;
  localparam int RANDOM_DAYS = 930;
  localparam longint ERA_DAYS     = 146097;
  localparam longint CENTURY_DAYS = 36524;
  localparam longint MARCH_FIRST  = 60;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [31:0]     m_tdata;

  day_count_to_calendar_date #(.DAY_BITS(DAY_BITS)) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) < 0) q = q - 1;
    return q;
  endfunction

  function automatic result_t civil_date(input logic [IN_W-1:0] word);
    longint  d, z, era, doe, yoe, yr, doy, mp, dom, mon;
    result_t r;
    d   = $signed(word[DAY_BITS-1:0]);
    z   = d - MARCH_FIRST;
    era = floor_div(z, ERA_DAYS);
    doe = z - era * ERA_DAYS;
    yoe = (doe - doe / 1460 + doe / CENTURY_DAYS - doe / (ERA_DAYS - 1)) / 365;
    yr  = yoe + era * 400;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    dom = doy - (153 * mp + 2) / 5;
    mon = (mp < 10) ? mp + 2 : mp - 10;
    if (mon < 2) yr = yr + 1;
    r.year        = yr[YEAR_W-1:0];
    r.month_index = mon[MONTH_W-1:0];
    r.day_index   = dom[DOM_W-1:0];
    r.weekday     = WD_W'((d - 1) - floor_div(d - 1, 7) * 7);
    return r;
  endfunction

  class date_board;
    result_t dates_due[$];
    int      errors;

    function void note_day(input logic [IN_W-1:0] word);
      dates_due.push_back(civil_date(word));
    endfunction

    function void check_date(input logic [31:0] word);
      result_t want;
      result_t got;
      got.year        = word[18:0];
      got.month_index = word[22:19];
      got.day_index   = word[27:23];
      got.weekday     = word[30:28];
      if (dates_due.size() == 0) begin
        $error("unexpected result item %h", word);
        errors++;
      end else begin
        want = dates_due.pop_front();
        if (got.year !== want.year) begin
          $error("year: expected %0d, got %0d", $signed(want.year), $signed(got.year));
          errors++;
        end
        if (got.month_index !== want.month_index) begin
          $error("month_index: expected %0d, got %0d", want.month_index, got.month_index);
          errors++;
        end
        if (got.day_index !== want.day_index) begin
          $error("day_index: expected %0d, got %0d", want.day_index, got.day_index);
          errors++;
        end
        if (got.weekday !== want.weekday) begin
          $error("weekday: expected %0d, got %0d", want.weekday, got.weekday);
          errors++;
        end
      end
    endfunction

    function int pending();
      return dates_due.size();
    endfunction
  endclass

  date_board board = new();

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [IN_W-1:0] random_day();
    int     r;
    longint v;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom();
    if (r < 65) begin
      v = longint'($urandom_range(0, 4000)) - 2000;
    end else if (r < 90) begin
      v = (longint'($urandom_range(0, 900)) - 450) * ERA_DAYS + MARCH_FIRST
          + longint'($urandom_range(0, 3)) * CENTURY_DAYS
          + longint'($urandom_range(0, 6)) - 3;
    end else begin
      v = longint'($signed($urandom()));
    end
    return {{(IN_W - DAY_BITS){1'b0}}, v[DAY_BITS-1:0]};
  endfunction

  task automatic send_day(input logic [IN_W-1:0] word);
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    board.note_day(word);
  endtask

  task automatic idle_input(input int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom();
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    idle_input(1);
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] day_word(input longint v);
    return {{(IN_W - DAY_BITS){1'b0}}, v[DAY_BITS-1:0]};
  endfunction

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #1600000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : input_side
    longint directed[$];
    directed = '{0, 1, -1, 6, 7, 31, 59, 60, 365, 366, -306, -307, -365, -366,
                 36583, 36584, 146156, 146157, -146037, -146038, -36464, -36465,
                 67108863, -67108864, -67108863};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      send_day(day_word(directed[i]));
      idle_input(gap_len());
    end
    // Bits above the day count are don't-care; the date must still be day 0.
    send_day({{(IN_W - DAY_BITS){1'b1}}, {DAY_BITS{1'b0}}});
    drain();
    for (int i = 0; i < RANDOM_DAYS; i++) begin
      send_day(random_day());
      if ((i / 100) % 3 != 0) idle_input(gap_len());
      if (i == RANDOM_DAYS / 2) drain();
    end
    drain();
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : result_side
    int hold;
    int results;
    int cyc;
    hold    = 0;
    results = 0;
    cyc     = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      cyc++;
      if (m_tvalid && m_tready) begin
        board.check_date(m_tdata);
        results++;
        // A long hold-off here backs the pipeline up into the input stream.
        if (results == 300) hold = 120;
      end
      if (hold == 0 && (cyc % 600) >= 150 && $urandom_range(0, 99) >= 60) hold = gap_len();
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire
